[hdl/rgb565_four_corner_gradient_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the four-corner gradient block
// Each macro expects clk and arst_n in scope at the point of use.
// ----------------------------------------------------------------------------
`ifndef RGB565_FOUR_CORNER_GRADIENT_ASSERT_SVH
`define RGB565_FOUR_CORNER_GRADIENT_ASSERT_SVH
`ifndef SYNTHESIS
`define RGBG_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define RGBG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define RGBG_ASSERT_SAME(lbl, ante, cons)
`define RGBG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hdl/rgbg_pkg.sv]
// ----------------------------------------------------------------------------
// rgbg_pkg
// Types and constants shared by the gradient pipeline modules.
// ----------------------------------------------------------------------------
`default_nettype none
package rgbg_pkg;
	// Largest pattern side; the fraction widths below are sized for it.
	localparam int MAX_DIMENSION = 4096;
	localparam int CHW       = 6;   // channel width, red and blue zero extended
	localparam int NUMW      = 12;  // fraction numerator and denominator width
	localparam int REMW      = 20;  // dividend and remainder width
	localparam int DVSW      = NUMW + 1;
	localparam int QSTEPS    = 6;   // quotient bits, one per cell
	localparam int CHAIN_LAT = QSTEPS + 2;
	localparam int PIPE_LAT  = 2 * CHAIN_LAT;

	localparam logic [2:0] REG_WIDTH  = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_TL     = 3'd2;
	localparam logic [2:0] REG_TR     = 3'd3;
	localparam logic [2:0] REG_BL     = 3'd4;
	localparam logic [2:0] REG_BR     = 3'd5;

	typedef struct packed {
		logic [REMW-1:0]   rem;
		logic [DVSW-1:0]   dvs;
		logic [QSTEPS-1:0] quo;
		logic [CHW-1:0]    base;
		logic              neg;
	} div_t;
endpackage
`default_nettype wire

[hdl/rgbg_div_cell.sv]
// ----------------------------------------------------------------------------
// rgbg_div_cell
// One restoring division step that settles a single quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none
module rgbg_div_cell #(
	parameter int SHIFT = 0
) (
	input  wire                 clk,
	input  wire                 en,
	input  wire rgbg_pkg::div_t d_in,
	output rgbg_pkg::div_t      d_out
);
	logic [rgbg_pkg::REMW-1:0] trial;
	rgbg_pkg::div_t            nxt;

	always_comb begin
		trial = rgbg_pkg::REMW'(d_in.dvs) << SHIFT;
		nxt   = d_in;
		if (d_in.rem >= trial) begin
			nxt.rem        = d_in.rem - trial;
			nxt.quo[SHIFT] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end
endmodule
`default_nettype wire

[hdl/rgbg_lerp.sv]
// ----------------------------------------------------------------------------
// rgbg_lerp
// Rounded channel interpolation a + round((b - a) * num / den) as a chain.
// ----------------------------------------------------------------------------
`default_nettype none
module rgbg_lerp (
	input  wire                             clk,
	input  wire                             en,
	input  wire [rgbg_pkg::CHW-1:0]         a,
	input  wire [rgbg_pkg::CHW-1:0]         b,
	input  wire [rgbg_pkg::NUMW-1:0]        num,
	input  wire [rgbg_pkg::NUMW-1:0]        den,
	output logic [rgbg_pkg::CHW-1:0]        y
);
	logic                                     neg;
	logic [rgbg_pkg::CHW-1:0]                 mag;
	logic [rgbg_pkg::CHW+rgbg_pkg::NUMW-1:0]  prod;
	rgbg_pkg::div_t                           head;
	rgbg_pkg::div_t                           head_s1;
	rgbg_pkg::div_t                           link [rgbg_pkg::QSTEPS+1];

	always_comb begin
		neg       = b < a;
		mag       = neg ? (a - b) : (b - a);
		prod      = mag * num;
		// Dividing 2*mag*num + den by 2*den rounds halves away from zero.
		head.rem  = rgbg_pkg::REMW'({prod, 1'b0}) + rgbg_pkg::REMW'(den);
		head.dvs  = {den, 1'b0};
		head.quo  = '0;
		head.base = a;
		head.neg  = neg;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			head_s1 <= head;
		end
	end

	assign link[0] = head_s1;

	for (genvar i = 0; i < rgbg_pkg::QSTEPS; i++) begin : g_cell
		rgbg_div_cell #(
			.SHIFT(rgbg_pkg::QSTEPS - 1 - i)
		) u_cell (
			.clk  (clk),
			.en   (en),
			.d_in (link[i]),
			.d_out(link[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y <= link[rgbg_pkg::QSTEPS].neg ?
				link[rgbg_pkg::QSTEPS].base - link[rgbg_pkg::QSTEPS].quo :
				link[rgbg_pkg::QSTEPS].base + link[rgbg_pkg::QSTEPS].quo;
		end
	end
endmodule
`default_nettype wire

[hdl/rgb565_four_corner_gradient.sv]
// ----------------------------------------------------------------------------
// rgb565_four_corner_gradient
// Four-corner RGB565 gradient generator with a streaming pixel interface.
// ----------------------------------------------------------------------------
// Usage: write width, height and the four corner colours through the cfg
// port (cfg_we, cfg_index, cfg_data) while no pixel is in flight. Then send
// coordinates on the s_ side: s_tdata holds pixel_row in bits 11..0 and
// pixel_column in bits 23..12. Each transfer yields one result on the m_
// side: m_tdata carries pixel_colour, m_tuser[0] carries in_range, and
// pixels outside the pattern come back as colour zero.
// Throughput is one pixel per clock while results are taken. From the
// input transfer to m_tvalid a pixel passes an 8-stage row interpolation
// chain, an 8-stage column interpolation chain and the output register.
// Each chain is a row of six restoring divider cells, one quotient bit per cell.
// Reset clears all configuration registers and every valid bit; the pipe
// is empty afterwards. When the receiver stalls with a result waiting, the
// whole pipe freezes and s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rgb565_four_corner_gradient_assert.svh"
module rgb565_four_corner_gradient (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_index,
	input  wire  [15:0] cfg_data,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,   // pixel_row [11:0], pixel_column [23:12]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,   // pixel_colour [15:0]
	output logic [0:0]  m_tuser    // in_range [0]
);
	localparam int LAT = rgbg_pkg::PIPE_LAT;
	localparam int CL  = rgbg_pkg::CHAIN_LAT;
	localparam int NW  = rgbg_pkg::NUMW;

	logic [12:0] width_q, height_q;
	logic [15:0] tl_q, tr_q, bl_q, br_q;
	logic [12:0] w_cl, h_cl;
	logic [11:0] row, col;
	logic        inr;
	logic [NW-1:0] rnum, rden, cnum, cden;
	logic        en;

	logic          vld_s   [LAT];
	logic          inr_s   [LAT];
	logic [NW-1:0] cnum_s  [CL];
	logic [NW-1:0] cden_s  [CL];

	logic [rgbg_pkg::CHW-1:0] lft [3];
	logic [rgbg_pkg::CHW-1:0] rgt [3];
	logic [rgbg_pkg::CHW-1:0] pix [3];
	logic [rgbg_pkg::CHW-1:0] ca_tl [3], ca_tr [3], ca_bl [3], ca_br [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= '0;
			height_q <= '0;
			tl_q     <= '0;
			tr_q     <= '0;
			bl_q     <= '0;
			br_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				rgbg_pkg::REG_WIDTH:  width_q  <= cfg_data[12:0];
				rgbg_pkg::REG_HEIGHT: height_q <= cfg_data[12:0];
				rgbg_pkg::REG_TL:     tl_q     <= cfg_data;
				rgbg_pkg::REG_TR:     tr_q     <= cfg_data;
				rgbg_pkg::REG_BL:     bl_q     <= cfg_data;
				rgbg_pkg::REG_BR:     br_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	always_comb begin
		w_cl = ({4'b0, width_q} > 17'(rgbg_pkg::MAX_DIMENSION)) ?
			13'(rgbg_pkg::MAX_DIMENSION) : width_q;
		h_cl = ({4'b0, height_q} > 17'(rgbg_pkg::MAX_DIMENSION)) ?
			13'(rgbg_pkg::MAX_DIMENSION) : height_q;
		row  = s_tdata[11:0];
		col  = s_tdata[23:12];
		inr  = ({1'b0, row} < h_cl) && ({1'b0, col} < w_cl);
		// A single row or column sits halfway between its two ends.
		rnum = (h_cl == 13'd1) ? NW'(1) : row;
		rden = (h_cl == 13'd1) ? NW'(2) : NW'(h_cl - 13'd1);
		cnum = (w_cl == 13'd1) ? NW'(1) : col;
		cden = (w_cl == 13'd1) ? NW'(2) : NW'(w_cl - 13'd1);
	end

	always_comb begin
		ca_tl[0] = {1'b0, tl_q[15:11]};
		ca_tl[1] = tl_q[10:5];
		ca_tl[2] = {1'b0, tl_q[4:0]};
		ca_tr[0] = {1'b0, tr_q[15:11]};
		ca_tr[1] = tr_q[10:5];
		ca_tr[2] = {1'b0, tr_q[4:0]};
		ca_bl[0] = {1'b0, bl_q[15:11]};
		ca_bl[1] = bl_q[10:5];
		ca_bl[2] = {1'b0, bl_q[4:0]};
		ca_br[0] = {1'b0, br_q[15:11]};
		ca_br[1] = br_q[10:5];
		ca_br[2] = {1'b0, br_q[4:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= s_tvalid;
			for (int i = 1; i < LAT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inr_s[0]  <= inr;
			cnum_s[0] <= cnum;
			cden_s[0] <= cden;
			for (int i = 1; i < LAT; i++) begin
				inr_s[i] <= inr_s[i-1];
			end
			for (int i = 1; i < CL; i++) begin
				cnum_s[i] <= cnum_s[i-1];
				cden_s[i] <= cden_s[i-1];
			end
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_chan
		rgbg_lerp u_left (
			.clk(clk), .en(en), .a(ca_tl[c]), .b(ca_bl[c]),
			.num(rnum), .den(rden), .y(lft[c])
		);
		rgbg_lerp u_right (
			.clk(clk), .en(en), .a(ca_tr[c]), .b(ca_br[c]),
			.num(rnum), .den(rden), .y(rgt[c])
		);
		rgbg_lerp u_col (
			.clk(clk), .en(en), .a(lft[c]), .b(rgt[c]),
			.num(cnum_s[CL-1]), .den(cden_s[CL-1]), .y(pix[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= vld_s[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tuser[0] <= inr_s[LAT-1];
			m_tdata    <= inr_s[LAT-1] ? {pix[0][4:0], pix[1], pix[2][4:0]} : 16'd0;
		end
	end

	`RGBG_ASSERT_SAME(a_out_of_range_black, m_tvalid && !m_tuser[0], m_tdata == 16'd0)
	`RGBG_ASSERT_NEXT(a_stall_freezes_pipe, !en, $stable(vld_s[LAT-1]) && $stable(m_tdata))
	`RGBG_ASSERT_NEXT(a_pipe_reaches_output, en && vld_s[LAT-1], m_tvalid)
endmodule
`default_nettype wire
